// ===== rtl/pci_bus_to_bridge_map_unit_macros.svh =====
// Assertion macros shared by the bus-to-bridge map checker.
// Depends on nothing; included by pbbm_chk.sv.
`ifndef PCI_BUS_TO_BRIDGE_MAP_UNIT_MACROS_SVH
`define PCI_BUS_TO_BRIDGE_MAP_UNIT_MACROS_SVH

// Same-cycle implication, reset-qualified
`define PBBM_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bus-to-bridge map: same-cycle check failed");

// Next-cycle implication, reset-qualified
`define PBBM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bus-to-bridge map: next-cycle check failed");

`endif

// ===== rtl/pbbm_pkg.sv =====
// Shared types, constants and microcode table of the bus-to-bridge map.
// Depends on nothing; used by every module of the block but pbbm_ram.
`default_nettype none

package pbbm_pkg;

	localparam int NUM_BUSES = 256;
	localparam int IDX_W     = $clog2(NUM_BUSES);
	localparam int HOP_W     = $clog2(NUM_BUSES + 1);

	// request opcodes
	localparam logic [1:0] OP_ADD  = 2'd0;
	localparam logic [1:0] OP_RM   = 2'd1;
	localparam logic [1:0] OP_FIND = 2'd2;

	// find status codes
	localparam logic [1:0] ST_NONE  = 2'd0;
	localparam logic [1:0] ST_FOUND = 2'd1;
	localparam logic [1:0] ST_LOOP  = 2'd2;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] bus_number;
		logic [7:0] device_function;
		logic       is_pci_bridge;
		logic [7:0] secondary_bus;
		logic [7:0] subordinate_bus;
	} req_t;

	typedef struct packed {
		logic [1:0] find_status;
		logic [7:0] bridge_bus;
		logic [7:0] bridge_devfn;
		logic [7:0] below_bus;
	} rsp_t;

	// table payload; the valid bit lives in flops
	typedef struct packed {
		logic [7:0] bus;
		logic [7:0] devfn;
	} entry_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'd0,
		S_RM_RD  = 3'd1,
		S_RM_CAP = 3'd2,
		S_WR     = 3'd3,
		S_FD_RD  = 3'd4,
		S_FD_HOP = 3'd5,
		S_DONE   = 3'd6
	} step_t;

	typedef enum logic [1:0] {
		JC_NONE     = 2'd0,
		JC_DISPATCH = 2'd1,
		JC_LAST     = 2'd2,
		JC_HOP_END  = 2'd3
	} jcond_t;

	typedef enum logic [1:0] {
		D_NONE = 2'd0,
		D_ADD  = 2'd1,
		D_RM   = 2'd2,
		D_FIND = 2'd3
	} disp_t;

	typedef enum logic {
		RA_CUR   = 1'b0,
		RA_RDATA = 1'b1
	} rasel_t;

	// one microcode word
	typedef struct packed {
		jcond_t cond;
		step_t  jt;
		step_t  nt;
		rasel_t rasel;
		logic   cap;
		logic   wr;
		logic   hop;
		logic   done;
	} ctrl_t;

	// datapath conditions seen by the sequencer
	typedef struct packed {
		logic  accept;
		disp_t disp;
		logic  last;
		logic  hop_end;
	} seq_flags_t;

	function automatic ctrl_t ucode(input step_t s);
		ctrl_t c;
		c = '0;
		unique case (s)
			S_IDLE: begin
				c.cond = JC_DISPATCH;
				c.nt   = S_IDLE;
			end
			S_RM_RD: begin
				c.nt = S_RM_CAP;
			end
			S_RM_CAP: begin
				c.cap = 1'b1;
				c.nt  = S_WR;
			end
			S_WR: begin
				c.wr   = 1'b1;
				c.cond = JC_LAST;
				c.jt   = S_DONE;
				c.nt   = S_WR;
			end
			S_FD_RD: begin
				c.nt = S_FD_HOP;
			end
			S_FD_HOP: begin
				c.hop   = 1'b1;
				c.rasel = RA_RDATA;
				c.cond  = JC_HOP_END;
				c.jt    = S_DONE;
				c.nt    = S_FD_HOP;
			end
			S_DONE: begin
				c.done = 1'b1;
				c.nt   = S_IDLE;
			end
			default: begin
				c.nt = S_IDLE;
			end
		endcase
		return c;
	endfunction

	function automatic step_t dispatch(input disp_t d);
		step_t s;
		unique case (d)
			D_ADD:   s = S_WR;
			D_RM:    s = S_RM_RD;
			D_FIND:  s = S_FD_RD;
			default: s = S_DONE;
		endcase
		return s;
	endfunction

	// true when a bus number lies within the table's index range
	function automatic logic in_tbl(input logic [7:0] b);
		return {1'b0, b} < 9'(NUM_BUSES);
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pbbm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// Depends on nothing.
`default_nettype none

module pbbm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write, then register the read word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/pbbm_seq.sv =====
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on pbbm_pkg.
`default_nettype none

module pbbm_seq import pbbm_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire seq_flags_t flags,
	output step_t           step,
	output ctrl_t           ctrl
);

	step_t step_q;
	step_t step_nxt;

	// hold the step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

	// fetch the control word and pick the next step
	always_comb begin
		ctrl = ucode(step_q);
		unique case (ctrl.cond)
			JC_NONE:     step_nxt = ctrl.nt;
			JC_DISPATCH: step_nxt = flags.accept ? dispatch(flags.disp) : ctrl.nt;
			JC_LAST:     step_nxt = flags.last ? ctrl.jt : ctrl.nt;
			JC_HOP_END:  step_nxt = flags.hop_end ? ctrl.jt : ctrl.nt;
			default:     step_nxt = S_IDLE;
		endcase
	end

	assign step = step_q;

endmodule

`default_nettype wire

// ===== rtl/pci_bus_to_bridge_map_unit.sv =====
// Top level of the PCI bus-to-bridge map: datapath, valid flops, table RAM.
// Depends on pbbm_pkg, pbbm_seq and pbbm_ram.
//
// Use: drive req and raise start while busy is low; the word is taken on that
// edge and busy rises. One result word per request appears on rsp for exactly
// one cycle with done high; the receiver cannot stall it. busy falls the cycle
// after done, so a new request may be presented with done.
// Opcodes: add bridge marks buses secondary..subordinate with the bridge;
// remove bridge copies the bridge's own bus entry over that range; find walks
// up from a bus to the topmost bridge. Non-bridge add/remove, an empty range
// and the spare opcode only echo the request.
// Steps: add writes the bridge into each bus of the range in turn; remove
// reads the bridge's own bus entry, captures it, then writes it over the
// range; find reads the start bus, then hops up the chain (up to 257 hops,
// loop reported after that); other requests go straight to the result word.
// Requests are handled one at a time; a new one is taken once busy is low.
// Reset clears the valid flops of all entries at once: the table reads as
// empty right after reset with no clearing pass.
`default_nettype none

module pci_bus_to_bridge_map_unit import pbbm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	output logic      busy,
	input  wire req_t req,
	output logic      done,
	output rsp_t      rsp
);

	step_t      step;
	ctrl_t      ctrl;
	seq_flags_t flags;

	logic [NUM_BUSES-1:0] valid_q;
	logic [7:0]           cur_q;
	logic [7:0]           devfn_q;
	logic [7:0]           below_q;
	logic [1:0]           status_q;
	logic [7:0]           ptr_q;
	logic [7:0]           sub_q;
	logic                 wval_q;
	entry_t               wdat_q;
	logic [HOP_W-1:0]     hops_q;

	entry_t           rdata;
	logic [IDX_W-1:0] raddr;
	logic             accept;
	logic             v_in;
	logic             v_cur;
	logic             v_rd;
	logic             wr_en;
	disp_t            disp;

	assign busy   = (step != S_IDLE);
	assign accept = start && !busy;

	// look up valid bits at the request bus, current bus and read-back bus
	assign v_in  = in_tbl(req.bus_number) && valid_q[req.bus_number[IDX_W-1:0]];
	assign v_cur = in_tbl(cur_q) && valid_q[cur_q[IDX_W-1:0]];
	assign v_rd  = in_tbl(rdata.bus) && valid_q[rdata.bus[IDX_W-1:0]];

	// classify the request for the dispatch jump
	always_comb begin
		priority if (req.opcode == OP_ADD && req.is_pci_bridge
				&& req.secondary_bus <= req.subordinate_bus) begin
			disp = D_ADD;
		end else if (req.opcode == OP_RM && req.is_pci_bridge
				&& req.secondary_bus <= req.subordinate_bus) begin
			disp = D_RM;
		end else if (req.opcode == OP_FIND && req.bus_number != 8'd0 && v_in) begin
			disp = D_FIND;
		end else begin
			disp = D_NONE;
		end
	end

	assign flags.accept  = accept;
	assign flags.disp    = disp;
	assign flags.last    = (ptr_q == sub_q);
	assign flags.hop_end = (hops_q == HOP_W'(NUM_BUSES)) || !v_rd;

	pbbm_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.step   (step),
		.ctrl   (ctrl)
	);

	// read the current bus, or chase the link just read
	assign raddr = (ctrl.rasel == RA_RDATA) ? rdata.bus[IDX_W-1:0] : cur_q[IDX_W-1:0];
	assign wr_en = ctrl.wr && in_tbl(ptr_q);

	pbbm_ram #(
		.WIDTH ($bits(entry_t)),
		.DEPTH (NUM_BUSES)
	) u_tbl (
		.clk   (clk),
		.we    (wr_en),
		.waddr (ptr_q[IDX_W-1:0]),
		.wdata (wdat_q),
		.raddr (raddr),
		.rdata (rdata)
	);

	// update valid flops with each table write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[ptr_q[IDX_W-1:0]] <= wval_q;
		end
	end

	// load the request, capture the copy source, advance the range, hop up
	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q    <= req.bus_number;
			devfn_q  <= req.device_function;
			below_q  <= 8'd0;
			status_q <= ST_NONE;
			ptr_q    <= req.secondary_bus;
			sub_q    <= req.subordinate_bus;
			wval_q   <= 1'b1;
			wdat_q   <= '{bus: req.bus_number, devfn: req.device_function};
			hops_q   <= '0;
		end
		if (ctrl.cap) begin
			wval_q <= v_cur;
			wdat_q <= rdata;
		end
		if (ctrl.wr) begin
			ptr_q <= ptr_q + 8'd1;
		end
		if (ctrl.hop) begin
			below_q  <= cur_q;
			devfn_q  <= rdata.devfn;
			cur_q    <= rdata.bus;
			hops_q   <= hops_q + HOP_W'(1);
			status_q <= (hops_q == HOP_W'(NUM_BUSES)) ? ST_LOOP : ST_FOUND;
		end
	end

	// drive the result word
	assign done             = ctrl.done;
	assign rsp.find_status  = status_q;
	assign rsp.bridge_bus   = cur_q;
	assign rsp.bridge_devfn = devfn_q;
	assign rsp.below_bus    = below_q;

endmodule

`default_nettype wire

// ===== rtl/pbbm_chk.sv =====
// Port-level checker for the bus-to-bridge map, bound to the top level.
// Depends on pbbm_pkg and pci_bus_to_bridge_map_unit_macros.svh.
`default_nettype none
`include "pci_bus_to_bridge_map_unit_macros.svh"

module pbbm_chk import pbbm_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire rsp_t rsp
);

	logic below_ok;
	logic code_ok;

	// no bridge means nothing below it
	assign below_ok = (rsp.find_status != ST_NONE) || (rsp.below_bus == 8'd0);

	// only the defined status codes appear
	assign code_ok = (rsp.find_status == ST_NONE) || (rsp.find_status == ST_FOUND)
		|| (rsp.find_status == ST_LOOP);

	// a result word only comes out of a request in flight
	`PBBM_ASSERT_IMPL(a_done_busy, clk, arst_n, done, busy)

	// a taken request keeps the block busy
	`PBBM_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy)

	// the block frees up right after its result word
	`PBBM_ASSERT_NEXT(a_done_free, clk, arst_n, done, !busy && !done)

	// no bridge means nothing below it
	`PBBM_ASSERT_IMPL(a_rsp_below, clk, arst_n, done, below_ok)

	// no unknown status
	`PBBM_ASSERT_IMPL(a_rsp_code, clk, arst_n, done, code_ok)

endmodule

bind pci_bus_to_bridge_map_unit pbbm_chk u_chk (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking bench for the PCI bus-to-bridge map: directed rows, then random requests,
// each result word checked against its row's fixed word or an in-bench model of the bridge table.
// Depends on pbbm_pkg and pci_bus_to_bridge_map_unit.
module testbench;
	import pbbm_pkg::*;

	localparam logic [1:0] OP_SPARE = 2'd3;
	localparam int RAND_ITEMS   = 1500;
	localparam int CALM_ITEMS   = 200;
	localparam int DRAIN_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 300;

	typedef struct {
		req_t rq;
		bit   fixed;
		rsp_t want;
	} vec_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic done;
	req_t req;
	rsp_t rsp;

	// model copy of the bridge table
	bit         link_valid [NUM_BUSES];
	logic [7:0] link_bus   [NUM_BUSES];
	logic [7:0] link_devfn [NUM_BUSES];

	rsp_t pending_rsp [$];
	vec_t dir_vecs [$];
	int   err_count;

	pci_bus_to_bridge_map_unit uut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic bit is_mapped(input int b);
		return b < NUM_BUSES && link_valid[b];
	endfunction

	// apply one request to the model table and return its result word
	function automatic rsp_t resolve_request(input req_t r);
		rsp_t       o;
		int         b;
		int         hops;
		logic [7:0] cur_bus;
		logic [7:0] cur_devfn;
		logic [7:0] below;
		bit         src_v;
		logic [7:0] src_bus;
		logic [7:0] src_devfn;
		cur_bus       = r.bus_number;
		cur_devfn     = r.device_function;
		below         = 8'd0;
		o.find_status = ST_NONE;
		if (r.opcode == OP_ADD && r.is_pci_bridge) begin
			// mark the range with this bridge
			for (b = int'(r.secondary_bus); b <= int'(r.subordinate_bus); b++) begin
				if (b < NUM_BUSES) begin
					link_valid[b] = 1'b1;
					link_bus[b]   = r.bus_number;
					link_devfn[b] = r.device_function;
				end
			end
		end else if (r.opcode == OP_RM && r.is_pci_bridge) begin
			// copy the bridge's own entry over the range
			for (b = int'(r.secondary_bus); b <= int'(r.subordinate_bus); b++) begin
				src_v     = 1'b0;
				src_bus   = 8'd0;
				src_devfn = 8'd0;
				if (int'(r.bus_number) < NUM_BUSES) begin
					src_v     = link_valid[r.bus_number];
					src_bus   = link_bus[r.bus_number];
					src_devfn = link_devfn[r.bus_number];
				end
				if (b < NUM_BUSES) begin
					link_valid[b] = src_v;
					link_bus[b]   = src_bus;
					link_devfn[b] = src_devfn;
				end
			end
		end else if (r.opcode == OP_FIND && cur_bus != 8'd0 && is_mapped(cur_bus)) begin
			// walk up the chain, give up after one hop past the table size
			hops          = 0;
			o.find_status = ST_FOUND;
			while (is_mapped(cur_bus)) begin
				below     = cur_bus;
				cur_devfn = link_devfn[cur_bus];
				cur_bus   = link_bus[cur_bus];
				if (hops >= NUM_BUSES) begin
					o.find_status = ST_LOOP;
					break;
				end
				hops++;
			end
		end
		o.bridge_bus   = cur_bus;
		o.bridge_devfn = cur_devfn;
		o.below_bus    = below;
		return o;
	endfunction

	// favor buses already in the table so chains grow deeper
	function automatic logic [7:0] pick_bus();
		int b;
		if ($urandom_range(0, 9) < 6) begin
			for (int i = 0; i < 8; i++) begin
				b = $urandom_range(0, NUM_BUSES - 1);
				if (is_mapped(b))
					return 8'(b);
			end
		end
		return 8'($urandom);
	endfunction

	function automatic req_t rand_req();
		req_t r;
		int   sel;
		int   lo;
		int   hi;
		int   b;
		r.opcode          = OP_FIND;
		r.bus_number      = 8'($urandom);
		r.device_function = 8'($urandom);
		r.is_pci_bridge   = 1'($urandom);
		r.secondary_bus   = 8'($urandom);
		r.subordinate_bus = 8'($urandom);
		sel               = $urandom_range(0, 99);
		if (sel < 55) begin
			// add or remove over a short range, mostly just below the bridge
			r.opcode        = (sel < 35) ? OP_ADD : OP_RM;
			r.is_pci_bridge = ($urandom_range(0, 9) != 0);
			r.bus_number    = pick_bus();
			if ($urandom_range(0, 9) < 7)
				lo = int'(r.bus_number) + $urandom_range(1, 16);
			else
				lo = $urandom_range(0, 255);
			if (lo > 255)
				lo = $urandom_range(1, 255);
			hi = lo + $urandom_range(0, 7);
			if (r.opcode == OP_ADD && $urandom_range(0, 49) == 0) begin
				lo = $urandom_range(1, 255);
				hi = 255;
			end
			if (hi > 255)
				hi = 255;
			if (lo < hi && $urandom_range(0, 19) == 0)
				{lo, hi} = {hi, lo};
			// now and then wipe the whole table from an unmapped bridge
			if (r.opcode == OP_RM && $urandom_range(0, 11) == 0) begin
				for (int i = 0; i < 16; i++) begin
					b = $urandom_range(0, 255);
					if (!is_mapped(b)) begin
						r.bus_number    = 8'(b);
						r.is_pci_bridge = 1'b1;
						lo              = 0;
						hi              = 255;
						break;
					end
				end
			end
			r.secondary_bus   = 8'(lo);
			r.subordinate_bus = 8'(hi);
		end else if (sel < 93) begin
			if ($urandom_range(0, 9) < 7)
				r.bus_number = pick_bus();
		end else if (sel < 97) begin
			r.opcode = OP_SPARE;
		end else begin
			r.opcode = 2'($urandom_range(0, 3));
		end
		return r;
	endfunction

	function automatic req_t mk_req(input logic [1:0] op, input logic [7:0] bus,
			input logic [7:0] devfn, input logic br, input logic [7:0] sec,
			input logic [7:0] sub);
		req_t r;
		r.opcode          = op;
		r.bus_number      = bus;
		r.device_function = devfn;
		r.is_pci_bridge   = br;
		r.secondary_bus   = sec;
		r.subordinate_bus = sub;
		return r;
	endfunction

	task automatic push_row(input req_t r, input bit fixed, input rsp_t want);
		vec_t v;
		v.rq    = r;
		v.fixed = fixed;
		v.want  = want;
		dir_vecs.push_back(v);
	endtask

	// present one word, hold it until taken, then idle for gap cycles
	task automatic send_word(input vec_t v, input int gap);
		rsp_t pred;
		@(negedge clk);
		start <= 1'b1;
		req   <= v.rq;
		do
			@(posedge clk);
		while (!(start && !busy));
		pred = resolve_request(v.rq);
		pending_rsp.push_back(v.fixed ? v.want : pred);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic flag_field(input string fld, input logic [7:0] want, input logic [7:0] got);
		$display("%0t: %s expected %h got %h", $time, fld, want, got);
		err_count++;
	endtask

	// compare each result word with the oldest pending one
	always @(posedge clk) begin : check_rsp
		rsp_t want;
		if (arst_n && done) begin
			if (pending_rsp.size() == 0) begin
				$display("%0t: result word with none pending, expected nothing got %h",
					$time, rsp);
				err_count++;
			end else begin
				want = pending_rsp.pop_front();
				if (want.find_status !== rsp.find_status)
					flag_field("find_status", 8'(want.find_status), 8'(rsp.find_status));
				if (want.bridge_bus !== rsp.bridge_bus)
					flag_field("bridge_bus", want.bridge_bus, rsp.bridge_bus);
				if (want.bridge_devfn !== rsp.bridge_devfn)
					flag_field("bridge_devfn", want.bridge_devfn, rsp.bridge_devfn);
				if (want.below_bus !== rsp.below_bus)
					flag_field("below_bus", want.below_bus, rsp.below_bus);
			end
		end
	end

	initial begin : watchdog
		#6000000;
		$display("pci_bus_to_bridge_map_unit: mismatch");
		$finish;
	end

	initial begin : stimulus
		vec_t v;
		int   w;
		err_count = 0;
		start     = 1'b0;
		req       = '0;
		arst_n    = 1'b0;
		for (int i = 0; i < NUM_BUSES; i++) begin
			link_valid[i] = 1'b0;
			link_bus[i]   = 8'd0;
			link_devfn[i] = 8'd0;
		end

		// empty table, bus zero, spare opcode, non-bridge device
		push_row(mk_req(OP_FIND, 8'd5, 8'h3c, 1'b1, 8'd0, 8'd0), 1'b1,
			rsp_t'{ST_NONE, 8'd5, 8'h3c, 8'd0});
		push_row(mk_req(OP_FIND, 8'd0, 8'hff, 1'b0, 8'hff, 8'hff), 1'b1,
			rsp_t'{ST_NONE, 8'd0, 8'hff, 8'd0});
		push_row(mk_req(OP_FIND, 8'd255, 8'h00, 1'b0, 8'd0, 8'd0), 1'b1,
			rsp_t'{ST_NONE, 8'd255, 8'h00, 8'd0});
		push_row(mk_req(OP_SPARE, 8'hff, 8'hff, 1'b1, 8'hff, 8'hff), 1'b1,
			rsp_t'{ST_NONE, 8'hff, 8'hff, 8'd0});
		push_row(mk_req(OP_ADD, 8'd1, 8'h08, 1'b0, 8'd2, 8'd4), 1'b1,
			rsp_t'{ST_NONE, 8'd1, 8'h08, 8'd0});
		push_row(mk_req(OP_FIND, 8'd3, 8'h11, 1'b0, 8'd0, 8'd0), 1'b1,
			rsp_t'{ST_NONE, 8'd3, 8'h11, 8'd0});
		// two-level chain
		push_row(mk_req(OP_ADD, 8'd0, 8'h10, 1'b1, 8'd1, 8'd1), 1'b1,
			rsp_t'{ST_NONE, 8'd0, 8'h10, 8'd0});
		push_row(mk_req(OP_ADD, 8'd1, 8'h18, 1'b1, 8'd2, 8'd9), 1'b1,
			rsp_t'{ST_NONE, 8'd1, 8'h18, 8'd0});
		push_row(mk_req(OP_FIND, 8'd5, 8'h00, 1'b0, 8'd0, 8'd0), 1'b0, '0);
		push_row(mk_req(OP_FIND, 8'd1, 8'h07, 1'b0, 8'd0, 8'd0), 1'b0, '0);
		// empty range
		push_row(mk_req(OP_ADD, 8'd7, 8'h20, 1'b1, 8'd20, 8'd10), 1'b1,
			rsp_t'{ST_NONE, 8'd7, 8'h20, 8'd0});
		push_row(mk_req(OP_FIND, 8'd15, 8'h01, 1'b0, 8'd0, 8'd0), 1'b1,
			rsp_t'{ST_NONE, 8'd15, 8'h01, 8'd0});
		// range up to the last bus
		push_row(mk_req(OP_ADD, 8'd2, 8'hf8, 1'b1, 8'd250, 8'd255), 1'b1,
			rsp_t'{ST_NONE, 8'd2, 8'hf8, 8'd0});
		push_row(mk_req(OP_FIND, 8'd255, 8'h02, 1'b0, 8'd0, 8'd0), 1'b0, '0);
		// bridge behind itself: chain loops
		push_row(mk_req(OP_ADD, 8'd40, 8'h21, 1'b1, 8'd40, 8'd40), 1'b1,
			rsp_t'{ST_NONE, 8'd40, 8'h21, 8'd0});
		push_row(mk_req(OP_FIND, 8'd40, 8'h00, 1'b0, 8'd0, 8'd0), 1'b1,
			rsp_t'{ST_LOOP, 8'd40, 8'h21, 8'd40});
		// removal: non-bridge first, then bridge
		push_row(mk_req(OP_RM, 8'd1, 8'h18, 1'b0, 8'd2, 8'd9), 1'b1,
			rsp_t'{ST_NONE, 8'd1, 8'h18, 8'd0});
		push_row(mk_req(OP_FIND, 8'd9, 8'h00, 1'b0, 8'd0, 8'd0), 1'b0, '0);
		push_row(mk_req(OP_RM, 8'd1, 8'h18, 1'b1, 8'd2, 8'd9), 1'b1,
			rsp_t'{ST_NONE, 8'd1, 8'h18, 8'd0});
		push_row(mk_req(OP_FIND, 8'd9, 8'h00, 1'b0, 8'd0, 8'd0), 1'b0, '0);
		push_row(mk_req(OP_RM, 8'd100, 8'h30, 1'b1, 8'd250, 8'd255), 1'b1,
			rsp_t'{ST_NONE, 8'd100, 8'h30, 8'd0});
		push_row(mk_req(OP_FIND, 8'd255, 8'h00, 1'b0, 8'd0, 8'd0), 1'b1,
			rsp_t'{ST_NONE, 8'd255, 8'h00, 8'd0});
		// nearly full range, then wipe everything
		push_row(mk_req(OP_ADD, 8'd0, 8'h55, 1'b1, 8'd1, 8'd255), 1'b1,
			rsp_t'{ST_NONE, 8'd0, 8'h55, 8'd0});
		push_row(mk_req(OP_FIND, 8'd128, 8'h00, 1'b0, 8'd0, 8'd0), 1'b0, '0);
		push_row(mk_req(OP_RM, 8'd0, 8'h55, 1'b1, 8'd0, 8'd255), 1'b1,
			rsp_t'{ST_NONE, 8'd0, 8'h55, 8'd0});
		push_row(mk_req(OP_FIND, 8'd128, 8'h66, 1'b0, 8'd0, 8'd0), 1'b1,
			rsp_t'{ST_NONE, 8'd128, 8'h66, 8'd0});

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_vecs[i])
			send_word(dir_vecs[i], ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0);

		// random phase; no idling near the end
		for (int i = 0; i < RAND_ITEMS; i++) begin
			v.rq    = rand_req();
			v.fixed = 1'b0;
			v.want  = '0;
			if (i >= RAND_ITEMS - CALM_ITEMS)
				send_word(v, 0);
			else
				send_word(v, ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0);
		end
		@(negedge clk);
		start <= 1'b0;

		// drain outstanding results
		w = 0;
		while (pending_rsp.size() != 0 && w < DRAIN_LIMIT) begin
			@(posedge clk);
			w++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_rsp.size() != 0) begin
			$display("%0t: %0d result words expected got none", $time, pending_rsp.size());
			err_count++;
		end

		if (err_count == 0)
			$display("pci_bus_to_bridge_map_unit: match");
		else
			$display("pci_bus_to_bridge_map_unit: mismatch");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/pbbm_pkg.sv
rtl/pbbm_ram.sv
rtl/pbbm_seq.sv
rtl/pci_bus_to_bridge_map_unit.sv
rtl/pbbm_chk.sv
verif/testbench.sv
